/* src/pressure_trend_regression_macros.svh */
// ---------------------------------------------------------------------------
// pressure trend regression assertion macros
// shorthand for clocked properties on clk with arst_n as the disable
// ---------------------------------------------------------------------------
`ifndef PRESSURE_TREND_REGRESSION_MACROS_SVH
`define PRESSURE_TREND_REGRESSION_MACROS_SVH

// consequent checked in the same cycle
`define PTREND_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// consequent checked in the cycle after the antecedent
`define PTREND_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* src/ptrend_pkg.sv */
// ---------------------------------------------------------------------------
// ptrend_pkg
// shared constants, widths and interface types of the pressure trend block
// ---------------------------------------------------------------------------
package ptrend_pkg;

	// history ring
	localparam int HISTORY_DEPTH = 64;
	localparam int PTR_W         = $clog2(HISTORY_DEPTH);

	// field widths
	localparam int P_W      = 17;
	localparam int T_W      = 22;
	localparam int TREND_W  = 25;
	localparam int Q_W      = TREND_W;

	// valid pressure window, exclusive bounds
	localparam logic [P_W-1:0] P_LOW_PA  = 17'd85000;
	localparam logic [P_W-1:0] P_HIGH_PA = 17'd110000;

	// register reset values
	localparam logic [T_W-1:0] INTERVAL_RESET = 22'd20000;
	localparam logic [P_W-1:0] FALLBACK_RESET = 17'd101325;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = T_W;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK        = 1'b1;

	// 1000 (milli hPa per hPa) * 60000 (ms per min) / 100 (Pa per hPa)
	localparam int K_W = 20;
	localparam logic [K_W-1:0] SCALE_NUM = 20'd600000;

	// regression constants over ages 0..n-1
	localparam longint SUM_X = longint'(HISTORY_DEPTH) * (HISTORY_DEPTH - 1) / 2;
	localparam longint DEN   = longint'(HISTORY_DEPTH) * HISTORY_DEPTH *
		(longint'(HISTORY_DEPTH) * HISTORY_DEPTH - 1) / 12;
	localparam int DEN_W     = $clog2(DEN + 1);

	// centred age weight n*i - sum(i), signed
	localparam int COEF_W = $clog2(SUM_X + 1) + 1;
	localparam logic signed [COEF_W-1:0] COEF_START = COEF_W'(-SUM_X);
	localparam logic signed [COEF_W-1:0] COEF_STEP  = COEF_W'(HISTORY_DEPTH);

	// numerator magnitude bound: 2^17 * n^3 / 4
	localparam int MAG_W = P_W + $clog2(longint'(HISTORY_DEPTH) * HISTORY_DEPTH *
		HISTORY_DEPTH / 4 + 1);
	localparam int X_W   = MAG_W + K_W;
	localparam int B_W   = DEN_W + T_W;
	localparam int ACC_W = ((X_W > B_W) ? X_W : B_W) + 1;

	// shared multiplier: two pieces of a wide operand, signed operands
	localparam int PIECE_W = 23;
	localparam int OP_W    = PIECE_W + 1;
	localparam int PROD_W  = 2 * OP_W;
	localparam logic [2*PIECE_W-1:0] DEN_V = (2 * PIECE_W)'(DEN);

	// divider step count
	localparam int DSTEP_W = $clog2(X_W + 1);

	// trend saturation limits
	localparam logic signed [TREND_W-1:0] TREND_MAX = {1'b0, {(TREND_W-1){1'b1}}};
	localparam logic signed [TREND_W-1:0] TREND_MIN = {1'b1, {(TREND_W-1){1'b0}}};

	// divider control and status
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_sts_t;

endpackage

/* src/ptrend_ram.sv */
// ---------------------------------------------------------------------------
// ptrend_ram
// simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module ptrend_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/ptrend_div.sv */
// ---------------------------------------------------------------------------
// ptrend_div
// restoring divider, one quotient bit per cycle, sticky overflow flag for the quotient
// ---------------------------------------------------------------------------
module ptrend_div import ptrend_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [X_W-1:0]   dividend,
	input  logic [B_W-1:0]   divisor,
	output div_sts_t         sts,
	output logic [Q_W-1:0]   quot
);

	logic               busy_q;
	logic               done_q;
	logic               ovf_q;
	logic [DSTEP_W-1:0] step_q;
	logic [X_W-1:0]     x_q;
	logic [B_W-1:0]     b_q;
	logic [B_W-1:0]     rem_q;
	logic [Q_W-1:0]     q_q;

	logic [B_W:0]       rem_sh;
	logic [B_W+1:0]     diff;
	logic               ge;

	// trial subtract of the divisor from the shifted remainder
	assign rem_sh = {rem_q, x_q[X_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, b_q};
	assign ge     = !diff[B_W+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !ctl.start && (step_q == DSTEP_W'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= DSTEP_W'(X_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == DSTEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath, one bit per cycle, sticky flag for quotient bits above the top
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= dividend;
			b_q   <= divisor;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			x_q   <= {x_q[X_W-2:0], 1'b0};
			rem_q <= ge ? diff[B_W-1:0] : rem_sh[B_W-1:0];
			q_q   <= {q_q[Q_W-2:0], ge};
			ovf_q <= ovf_q | q_q[Q_W-1];
		end
	end

	assign sts.done = done_q;
	assign sts.ovf  = ovf_q;
	assign quot     = q_q;

endmodule

/* src/pressure_trend_regression.sv */
// ---------------------------------------------------------------------------
// pressure_trend_regression
// barometric history ring with least-squares trend in milli hPa per minute
//
//   channel | signals                                   | transfer
//   --------+-------------------------------------------+------------------
//   sample  | sample_valid, sample_ready, pressure_pa   | valid/ready beat
//   result  | result_valid, result_ready, accepted,     | valid/ready beat
//           | current_pressure_pa, trend_millihpa_per_min|
//   config  | cfg_write, cfg_index, cfg_wdata           | write on cfg_write
//
// after a sample beat the history entries go through the shared multiplier at one entry
// per cycle, then a drain, two wide products, then one quotient bit per cycle in the
// serial divider; a flat history skips the products and divide. after reset the first
// beat fills the ring. sample_ready is low while a beat is worked on; a finished result
// waits in the output register while the next sample is taken, and the next result waits
// behind it.
// ---------------------------------------------------------------------------
module pressure_trend_regression import ptrend_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic [P_W-1:0]             pressure_pa,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic                       accepted,
	output logic [P_W-1:0]             current_pressure_pa,
	output logic signed [TREND_W-1:0]  trend_millihpa_per_min
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRIME,
		ST_SUM,
		ST_SUM_END,
		ST_MULK,
		ST_MULK_END,
		ST_MULB,
		ST_MULB_END,
		ST_DIV,
		ST_OUT
	} state_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [T_W-1:0] interval_q;
	logic [P_W-1:0] fallback_q;

	// control and item state
	state_t                    state_q;
	logic                      primed_q;
	logic [PTR_W-1:0]          wp_q;
	logic [PTR_W-1:0]          rd_ptr_q;
	logic [PTR_W-1:0]          cnt_q;
	logic signed [COEF_W-1:0]  coef_q;
	logic                      piece_q;
	logic [P_W-1:0]            pnow_q;
	logic                      flag_q;
	logic                      neg_q;
	logic [MAG_W-1:0]          mag_q;
	logic [X_W-1:0]            x_q;
	logic signed [TREND_W-1:0] trend_q;
	logic                      res_valid_q;
	logic                      res_acc_q;
	logic [P_W-1:0]            res_p_q;
	logic signed [TREND_W-1:0] res_trend_q;

	// datapath pipeline
	logic                      rd_vld_s1;
	logic signed [COEF_W-1:0]  coef_s1;
	logic                      vld_s2;
	logic                      hi_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;

	logic                      accept;
	logic                      in_window;
	logic                      pipe_empty;
	logic                      acc_clr;
	logic                      ram_we;
	logic [PTR_W-1:0]          ram_waddr;
	logic [P_W-1:0]            ram_wdata;
	logic                      ram_re;
	logic [P_W-1:0]            ram_rdata;
	logic [T_W-1:0]            interval_eff;
	logic [2*PIECE_W-1:0]      mag_ext;
	logic                      mul_go;
	logic                      mul_hi;
	logic signed [OP_W-1:0]    mul_a;
	logic signed [OP_W-1:0]    mul_b;
	logic signed [ACC_W-1:0]   addend;
	logic [ACC_W-1:0]          acc_abs;
	div_ctl_t                  div_ctl;
	div_sts_t                  div_sts;
	logic [Q_W-1:0]            div_quot;
	logic signed [TREND_W-1:0] trend_sat;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign in_window    = (pressure_pa > P_LOW_PA) && (pressure_pa < P_HIGH_PA);
	assign pipe_empty   = !rd_vld_s1 && !vld_s2;
	assign interval_eff = (interval_q == '0) ? T_W'(1) : interval_q;
	assign mag_ext      = (2 * PIECE_W)'(mag_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			fallback_q <= FALLBACK_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SAMPLE_INTERVAL: interval_q <= cfg_wdata;
				CFG_FALLBACK:        fallback_q <= cfg_wdata[P_W-1:0];
				default: ;
			endcase
		end
	end

	// history ring: new in-window sample at accept once primed, whole ring while priming
	assign ram_we    = (accept && primed_q && in_window) || (state_q == ST_PRIME);
	assign ram_waddr = (state_q == ST_PRIME) ? rd_ptr_q : wp_q;
	assign ram_wdata = (state_q == ST_PRIME) ? pnow_q : pressure_pa;
	assign ram_re    = (state_q == ST_SUM);

	ptrend_ram #(
		.WIDTH (P_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// shared multiplier operand select
	always_comb begin
		mul_go = 1'b0;
		mul_hi = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		if (rd_vld_s1) begin
			mul_go = 1'b1;
			mul_a  = OP_W'(coef_s1);
			mul_b  = OP_W'(ram_rdata);
		end else if (state_q == ST_MULK) begin
			mul_go = 1'b1;
			mul_hi = piece_q;
			mul_a  = piece_q ? OP_W'(mag_ext[2*PIECE_W-1:PIECE_W])
			                 : OP_W'(mag_ext[PIECE_W-1:0]);
			mul_b  = OP_W'(SCALE_NUM);
		end else if (state_q == ST_MULB) begin
			mul_go = 1'b1;
			mul_hi = piece_q;
			mul_a  = piece_q ? OP_W'(DEN_V[2*PIECE_W-1:PIECE_W])
			                 : OP_W'(DEN_V[PIECE_W-1:0]);
			mul_b  = OP_W'(interval_eff);
		end
	end

	// upper pieces land one piece width up
	assign addend  = hi_s2 ? (ACC_W'(prod_s2) <<< PIECE_W) : ACC_W'(prod_s2);
	assign acc_clr = (state_q == ST_IDLE) ||
		(((state_q == ST_SUM_END) || (state_q == ST_MULK_END)) && pipe_empty);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			vld_s2    <= mul_go;
		end
	end

	// read, multiply, accumulate
	always_ff @(posedge clk) begin
		coef_s1 <= coef_q;
		prod_s2 <= mul_a * mul_b;
		hi_s2   <= mul_hi;
		if (acc_clr) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + addend;
		end
	end

	assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

	// serial divide of scaled numerator by denominator times interval
	assign div_ctl.start = (state_q == ST_MULB_END) && pipe_empty;

	ptrend_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (x_q),
		.divisor  (acc_q[B_W-1:0]),
		.sts      (div_sts),
		.quot     (div_quot)
	);

	// sign and saturate the quotient
	always_comb begin
		if (neg_q) begin
			trend_sat = (div_sts.ovf || div_quot[Q_W-1]) ? TREND_MIN
			                                             : TREND_W'(-div_quot);
		end else begin
			trend_sat = (div_sts.ovf || div_quot[Q_W-1]) ? TREND_MAX
			                                             : TREND_W'(div_quot);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			primed_q    <= 1'b0;
			wp_q        <= '0;
			pnow_q      <= '0;
			res_valid_q <= 1'b0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
			coef_q      <= '0;
			piece_q     <= 1'b0;
			flag_q      <= 1'b0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			x_q         <= '0;
			trend_q     <= '0;
			res_acc_q   <= 1'b0;
			res_p_q     <= '0;
			res_trend_q <= '0;
		end else begin
			if (result_ready && (state_q != ST_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						flag_q  <= in_window;
						cnt_q   <= '0;
						coef_q  <= COEF_START;
						piece_q <= 1'b0;
						if (!primed_q) begin
							primed_q <= 1'b1;
							pnow_q   <= in_window ? pressure_pa : fallback_q;
							wp_q     <= '0;
							rd_ptr_q <= '0;
							state_q  <= ST_PRIME;
						end else begin
							if (in_window) begin
								pnow_q   <= pressure_pa;
								wp_q     <= ptr_inc(wp_q);
								rd_ptr_q <= ptr_inc(wp_q);
							end else begin
								rd_ptr_q <= wp_q;
							end
							state_q <= ST_SUM;
						end
					end
				end
				// fill every entry, a flat history has no slope
				ST_PRIME: begin
					rd_ptr_q <= ptr_inc(rd_ptr_q);
					if (rd_ptr_q == PTR_W'(HISTORY_DEPTH - 1)) begin
						trend_q <= '0;
						state_q <= ST_OUT;
					end
				end
				// oldest first, weight steps by the depth
				ST_SUM: begin
					rd_ptr_q <= ptr_inc(rd_ptr_q);
					coef_q   <= coef_q + COEF_STEP;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == PTR_W'(HISTORY_DEPTH - 1)) begin
						state_q <= ST_SUM_END;
					end
				end
				ST_SUM_END: begin
					if (pipe_empty) begin
						if ((acc_q == '0) || (HISTORY_DEPTH < 3)) begin
							trend_q <= '0;
							state_q <= ST_OUT;
						end else begin
							neg_q   <= acc_q[ACC_W-1];
							mag_q   <= acc_abs[MAG_W-1:0];
							state_q <= ST_MULK;
						end
					end
				end
				ST_MULK: begin
					piece_q <= !piece_q;
					if (piece_q) begin
						state_q <= ST_MULK_END;
					end
				end
				ST_MULK_END: begin
					if (pipe_empty) begin
						x_q     <= acc_q[X_W-1:0];
						state_q <= ST_MULB;
					end
				end
				ST_MULB: begin
					piece_q <= !piece_q;
					if (piece_q) begin
						state_q <= ST_MULB_END;
					end
				end
				ST_MULB_END: begin
					if (pipe_empty) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						trend_q <= trend_sat;
						state_q <= ST_OUT;
					end
				end
				// hand the result to the output register once it is free
				ST_OUT: begin
					if (!res_valid_q || result_ready) begin
						res_valid_q <= 1'b1;
						res_acc_q   <= flag_q;
						res_p_q     <= pnow_q;
						res_trend_q <= trend_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid           = res_valid_q;
	assign accepted               = res_acc_q;
	assign current_pressure_pa    = res_p_q;
	assign trend_millihpa_per_min = res_trend_q;

endmodule

/* src/ptrend_checker.sv */
// ---------------------------------------------------------------------------
// ptrend_checker
// port level checks on the pressure trend block, bound to the top level
// ---------------------------------------------------------------------------
`include "pressure_trend_regression_macros.svh"

module ptrend_checker import ptrend_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       sample_valid,
	input logic                       sample_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic                       accepted,
	input logic [P_W-1:0]             current_pressure_pa,
	input logic signed [TREND_W-1:0]  trend_millihpa_per_min
);

	logic                        res_stall;
	logic [P_W+TREND_W+1:0]      res_beat;
	logic                        sample_beat;
	logic                        acc_beat;
	logic                        in_window;

	assign res_stall   = result_valid && !result_ready;
	assign res_beat    = {result_valid, accepted, current_pressure_pa, trend_millihpa_per_min};
	assign sample_beat = sample_valid && sample_ready;
	assign acc_beat    = result_valid && accepted;
	assign in_window   = (current_pressure_pa > P_LOW_PA) && (current_pressure_pa < P_HIGH_PA);

	// a stalled result beat holds
	`PTREND_ASSERT_NEXT(a_result_hold, res_stall, $stable(res_beat), "stalled result beat changed")

	// one sample at a time: busy right after a sample beat
	`PTREND_ASSERT_NEXT(a_busy_after_sample, sample_beat, !sample_ready, "sample taken while busy")

	// an accepted reading is always inside the window
	`PTREND_ASSERT_SAME(a_accepted_window, acc_beat, in_window, "accepted pressure out of window")

endmodule

bind pressure_trend_regression ptrend_checker u_ptrend_checker (.*);
